[hw/rtl/info_frame_deframer_unit_defines.svh]
// assertion macros for the info frame deframer checker
// no dependencies; expects clk_i and rst_ni in the scope of use
`ifndef INFO_FRAME_DEFRAMER_UNIT_DEFINES_SVH
`define INFO_FRAME_DEFRAMER_UNIT_DEFINES_SVH

// checked only outside reset
`define IFDU_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked in reset as well
`define IFDU_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[hw/rtl/ifdu_pkg.sv]
// types and constants of the info frame deframer
// no dependencies
package ifdu_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned LEN_W     = 11;
  localparam int unsigned KIND_W    = 3;
  localparam int unsigned CFG_IDX_W = 3;

  typedef logic [BYTE_W-1:0] byte_t;

  typedef enum logic [5:0] {
    PH_HUNT = 6'b000001,
    PH_ADDR = 6'b000010,
    PH_CTRL = 6'b000100,
    PH_HCHK = 6'b001000,
    PH_DATA = 6'b010000,
    PH_ESC  = 6'b100000
  } phase_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_DATA      = 3'd0,
    KIND_ACCEPT    = 3'd1,
    KIND_MISMATCH  = 3'd2,
    KIND_DUPLICATE = 3'd3,
    KIND_BAD_SIZE  = 3'd4
  } kind_e;

  localparam logic [CFG_IDX_W-1:0] CFG_FLAG      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STUF_FLAG = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STUF_ESC  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ADDRESS   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CTRL_SEQ0 = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_CTRL_SEQ1 = 3'd6;

  localparam byte_t RST_FLAG      = 8'd126;
  localparam byte_t RST_ESCAPE    = 8'd125;
  localparam byte_t RST_STUF_FLAG = 8'd94;
  localparam byte_t RST_STUF_ESC  = 8'd93;
  localparam byte_t RST_ADDRESS   = 8'd3;
  localparam byte_t RST_CTRL_SEQ0 = 8'd0;
  localparam byte_t RST_CTRL_SEQ1 = 8'd64;

endpackage

[hw/rtl/info_frame_deframer_unit.sv]
// info frame deframer: flag hunt, header match, destuffing, data check
// depends on ifdu_pkg
//
// channel  | handshake             | payload
// ---------+-----------------------+-------------------------------------------
// in       | in_valid_i/in_ready_o | line_byte_i
// out      | out_valid_o/out_ready_i | result_kind_o, payload_byte_o,
//          |                       | payload_length_o, sequence_now_o
// config   | cfg_we_i              | cfg_idx_i, cfg_data_i
//
// one line byte per cycle while in_ready_o is high; frame state and result
// register update together on the in transfer, result visible the cycle after
// in_ready_o is low only while a result waits and out_ready_i is low
// reset returns to flag hunting with sequence zero and register defaults
module info_frame_deframer_unit #(
  parameter int unsigned MaxPayload = 1024
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ifdu_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ifdu_pkg::BYTE_W-1:0]    cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [ifdu_pkg::BYTE_W-1:0]    line_byte_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [ifdu_pkg::KIND_W-1:0]    result_kind_o,
  output logic [ifdu_pkg::BYTE_W-1:0]    payload_byte_o,
  output logic [ifdu_pkg::LEN_W-1:0]     payload_length_o,
  output logic                           sequence_now_o
);
  import ifdu_pkg::*;

  localparam int unsigned CntW = $clog2(MaxPayload + 1);

  byte_t flag_q, esc_q, sflag_q, sesc_q, addr_q, ctl0_q, ctl1_q;

  phase_e          phase_q, phase_d;
  logic            seq_q, seq_d;
  byte_t           chk_q, chk_d;
  byte_t           held_q, held_d;
  logic            hv_q, hv_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            tl_q, tl_d;

  logic            out_valid_q;
  kind_e           kind_q, kind_n;
  byte_t           byte_q, byte_n;
  logic [LEN_W-1:0] len_q;
  logic [CntW-1:0] len_n;
  logic [CntW+LEN_W-1:0] len_ext;
  logic            seqo_q;

  logic  in_xfer, emit, take;
  byte_t b, want, other, take_byte;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_xfer    = in_valid_i && in_ready_o;
  assign b          = line_byte_i;
  assign want       = seq_q ? ctl1_q : ctl0_q;
  assign other      = seq_q ? ctl0_q : ctl1_q;
  assign len_ext    = {{LEN_W{1'b0}}, len_n};

  always_comb begin
    phase_d   = phase_q;
    seq_d     = seq_q;
    chk_d     = chk_q;
    held_d    = held_q;
    hv_d      = hv_q;
    cnt_d     = cnt_q;
    tl_d      = tl_q;
    emit      = 1'b0;
    kind_n    = KIND_DATA;
    byte_n    = '0;
    len_n     = '0;
    take      = 1'b0;
    take_byte = '0;
    if (in_xfer) begin
      case (phase_q)
        PH_HUNT: begin
          if (b == flag_q) phase_d = PH_ADDR;
        end
        PH_ADDR: begin
          if (b == addr_q) phase_d = PH_CTRL;
          else if (b != flag_q) phase_d = PH_HUNT;
        end
        PH_CTRL: begin
          if (b == want) begin
            phase_d = PH_HCHK;
          end else if (b == other) begin
            phase_d = PH_HUNT;
            emit    = 1'b1;
            kind_n  = KIND_DUPLICATE;
          end else begin
            phase_d = (b == flag_q) ? PH_ADDR : PH_HUNT;
          end
        end
        PH_HCHK: begin
          if (b == (want ^ addr_q)) begin
            chk_d   = b;
            held_d  = '0;
            hv_d    = 1'b0;
            cnt_d   = '0;
            tl_d    = 1'b0;
            phase_d = PH_DATA;
          end else begin
            phase_d = (b == flag_q) ? PH_ADDR : PH_HUNT;
          end
        end
        PH_DATA: begin
          if (b == flag_q) begin
            phase_d = PH_HUNT;
            emit    = 1'b1;
            len_n   = cnt_q;
            if (!hv_q || tl_q) begin
              kind_n = KIND_BAD_SIZE;
            end else if (held_q == chk_q) begin
              seq_d  = ~seq_q;
              kind_n = KIND_ACCEPT;
            end else begin
              kind_n = KIND_MISMATCH;
            end
          end else if (b == esc_q) begin
            phase_d = PH_ESC;
          end else begin
            take      = 1'b1;
            take_byte = b;
          end
        end
        PH_ESC: begin
          phase_d = PH_DATA;
          if (b == sflag_q) begin
            take      = 1'b1;
            take_byte = flag_q;
          end else if (b == sesc_q) begin
            take      = 1'b1;
            take_byte = esc_q;
          end
        end
        default: phase_d = PH_HUNT;
      endcase
    end
    // held byte released one byte late, check byte stays held
    if (take) begin
      if (hv_q) begin
        if (!tl_q && (cnt_q < CntW'(MaxPayload))) begin
          chk_d  = chk_q ^ held_q;
          cnt_d  = cnt_q + CntW'(1);
          emit   = 1'b1;
          kind_n = KIND_DATA;
          byte_n = held_q;
          len_n  = cnt_q + CntW'(1);
        end else begin
          tl_d = 1'b1;
        end
      end
      held_d = take_byte;
      hv_d   = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag_q  <= RST_FLAG;
      esc_q   <= RST_ESCAPE;
      sflag_q <= RST_STUF_FLAG;
      sesc_q  <= RST_STUF_ESC;
      addr_q  <= RST_ADDRESS;
      ctl0_q  <= RST_CTRL_SEQ0;
      ctl1_q  <= RST_CTRL_SEQ1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_FLAG:      flag_q  <= cfg_data_i;
        CFG_ESCAPE:    esc_q   <= cfg_data_i;
        CFG_STUF_FLAG: sflag_q <= cfg_data_i;
        CFG_STUF_ESC:  sesc_q  <= cfg_data_i;
        CFG_ADDRESS:   addr_q  <= cfg_data_i;
        CFG_CTRL_SEQ0: ctl0_q  <= cfg_data_i;
        CFG_CTRL_SEQ1: ctl1_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HUNT;
      seq_q       <= 1'b0;
      chk_q       <= '0;
      held_q      <= '0;
      hv_q        <= 1'b0;
      cnt_q       <= '0;
      tl_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      seq_q   <= seq_d;
      chk_q   <= chk_d;
      held_q  <= held_d;
      hv_q    <= hv_d;
      cnt_q   <= cnt_d;
      tl_q    <= tl_d;
      if (in_xfer) out_valid_q <= emit;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // result payload, loaded only when the output stage is free or being read out
  always_ff @(posedge clk_i) begin
    if (in_xfer && emit) begin
      kind_q <= kind_n;
      byte_q <= byte_n;
      len_q  <= len_ext[LEN_W-1:0];
      seqo_q <= seq_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign result_kind_o    = kind_q;
  assign payload_byte_o   = byte_q;
  assign payload_length_o = len_q;
  assign sequence_now_o   = seqo_q;

endmodule

[hw/rtl/ifdu_checker.sv]
// port-level checks for info_frame_deframer_unit, bound into every instance
// depends on ifdu_pkg and info_frame_deframer_unit_defines.svh
`include "info_frame_deframer_unit_defines.svh"

module ifdu_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           cfg_we_i,
  input logic [ifdu_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input logic [ifdu_pkg::BYTE_W-1:0]    cfg_data_i,
  input logic                           in_valid_i,
  input logic                           in_ready_o,
  input logic [ifdu_pkg::BYTE_W-1:0]    line_byte_i,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input logic [ifdu_pkg::KIND_W-1:0]    result_kind_o,
  input logic [ifdu_pkg::BYTE_W-1:0]    payload_byte_o,
  input logic [ifdu_pkg::LEN_W-1:0]     payload_length_o,
  input logic                           sequence_now_o
);
  import ifdu_pkg::*;

  `IFDU_ASSERT_RST(a_no_result_in_reset, !rst_ni |-> !out_valid_o, "result during reset")

  `IFDU_ASSERT(a_stall_holds, out_valid_o && !out_ready_i |=> out_valid_o && $stable(result_kind_o) && $stable(payload_length_o) && $stable(sequence_now_o), "stalled result changed")

  `IFDU_ASSERT(a_ready_when_free, !out_valid_o |-> in_ready_o, "input stalled with empty output")

  `IFDU_ASSERT(a_byte_only_data, out_valid_o && result_kind_o != KIND_DATA |-> payload_byte_o == '0, "payload byte on frame result")

  `IFDU_ASSERT(a_dup_no_length, out_valid_o && result_kind_o == KIND_DUPLICATE |-> payload_length_o == '0, "length on duplicate")

endmodule

bind info_frame_deframer_unit ifdu_checker u_ifdu_checker (.*);
